### hw/rtl/lbpp_pkg.sv
// ----------------------------------------------------------------------------
// lbpp_pkg: shared types and constants of the LED blink pattern player
// Request and result words, request codes, pattern symbol codes and the
// pattern store geometry.
// ----------------------------------------------------------------------------
package lbpp_pkg;

	// Pattern store geometry
	localparam int PATTERN_DEPTH = 512;
	localparam int IDX_W         = 9;
	localparam int ADDR_W        = (PATTERN_DEPTH > 1) ? $clog2(PATTERN_DEPTH) : 1;
	localparam int LEN_W         = $clog2(PATTERN_DEPTH + 1);
	localparam int WIDE_W        = ((ADDR_W > IDX_W) ? ADDR_W : IDX_W) + 1;
	localparam int HOLD_W        = 4;

	// Request codes
	localparam logic [1:0] REQ_TICK   = 2'd0;
	localparam logic [1:0] REQ_LOAD   = 2'd1;
	localparam logic [1:0] REQ_STEADY = 2'd2;

	// Pattern symbols
	localparam logic [7:0] SYM_STOP      = 8'h2E; // '.'
	localparam logic [7:0] SYM_SEC_ON    = 8'h55; // 'U'
	localparam logic [7:0] SYM_SEC_OFF   = 8'h75; // 'u'
	localparam logic [7:0] SYM_OFF_FIRST = 8'h61; // 'a'
	localparam logic [7:0] SYM_OFF_LAST  = 8'h6A; // 'j'
	localparam logic [7:0] SYM_ON_FIRST  = 8'h41; // 'A'
	localparam logic [7:0] SYM_ON_LAST   = 8'h4A; // 'J'
	localparam logic [HOLD_W-1:0] HOLD_MASK = 4'hF;

	typedef struct packed {
		logic [1:0]       req_type;
		logic [31:0]      current_second;
		logic [7:0]       pattern_symbol;
		logic [IDX_W-1:0] symbol_index;
		logic             last_symbol;
		logic             steady_level;
	} req_t;

	typedef struct packed {
		logic led_level;
		logic level_driven;
		logic blinking;
		logic load_error;
	} rsp_t;

endpackage

### hw/rtl/led_blink_pattern_player.sv
// ----------------------------------------------------------------------------
// led_blink_pattern_player: plays a stored blink pattern on one LED
// Load words fill the pattern store, tick words step playback, steady words
// force a fixed level. One result word per request word.
// ----------------------------------------------------------------------------
// Pipeline: a request word is registered in stage 1 at accept, and its result word in the output register.
// Throughput: one word per cycle while no stall holds the flow; the single pattern memory
//   read per word is addressed with the play position as left by the word one stage ahead.
// Reset: arst_n clears playback state and both pipeline valids at once; the
//   pattern store is not cleared and holds garbage until written.
module led_blink_pattern_player (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  lbpp_pkg::req_t  req_word,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output lbpp_pkg::rsp_t  rsp_word
);

	localparam int AW = lbpp_pkg::ADDR_W;
	localparam int LW = lbpp_pkg::LEN_W;
	localparam int WW = lbpp_pkg::WIDE_W;
	localparam int HW = lbpp_pkg::HOLD_W;

	// Pattern store and stage 1 registers
	logic [7:0]     mem [lbpp_pkg::PATTERN_DEPTH];
	logic [7:0]     rdata_s1;
	logic           valid_s1;
	lbpp_pkg::req_t req_s1;

	// Playback state
	logic [AW-1:0] pos_q;
	logic [LW-1:0] len_q;
	logic [HW-1:0] hold_q;
	logic [31:0]   lsec_q;
	logic          play_q;

	logic [AW-1:0] pos_n;
	logic [LW-1:0] len_n;
	logic [HW-1:0] hold_n;
	logic [31:0]   lsec_n;
	logic          play_n;
	lbpp_pkg::rsp_t rsp_n;

	logic          adv_s1;
	logic          accept;
	logic          wr_en;
	logic [WW-1:0] widx_in;
	logic [WW-1:0] widx_s1;
	logic          range_s1;
	logic [LW-1:0] pos_inc;
	logic          advance;

	// Handshake
	assign adv_s1    = valid_s1 && (!rsp_valid || !rsp_stall);
	assign req_stall = valid_s1 && !adv_s1;
	assign accept    = req_valid && !req_stall;

	// Store write at accept, for in-range load words
	assign widx_in = WW'(req_word.symbol_index);
	assign wr_en   = accept && (req_word.req_type == lbpp_pkg::REQ_LOAD) &&
		(widx_in < WW'(lbpp_pkg::PATTERN_DEPTH));

	// Memory: write at load index, read at the next play position
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[widx_in[AW-1:0]] <= req_word.pattern_symbol;
		end
		if (accept) begin
			rdata_s1 <= mem[pos_n];
		end
	end

	// Stage 1 word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1 <= req_word;
		end
	end

	// Word evaluation against playback state
	assign widx_s1  = WW'(req_s1.symbol_index);
	assign range_s1 = widx_s1 < WW'(lbpp_pkg::PATTERN_DEPTH);
	assign pos_inc  = LW'(pos_q) + LW'(1);

	always_comb begin
		pos_n   = pos_q;
		len_n   = len_q;
		hold_n  = hold_q;
		lsec_n  = lsec_q;
		play_n  = play_q;
		rsp_n   = '0;
		advance = 1'b0;
		if (valid_s1) begin
			case (req_s1.req_type)
				lbpp_pkg::REQ_LOAD: begin
					if (!range_s1) begin
						rsp_n.load_error = 1'b1;
					end else if (req_s1.last_symbol) begin
						len_n  = LW'(widx_s1 + WW'(1));
						pos_n  = '0;
						hold_n = '0;
						play_n = 1'b1;
					end
				end
				lbpp_pkg::REQ_STEADY: begin
					play_n             = 1'b0;
					hold_n             = '0;
					rsp_n.led_level    = req_s1.steady_level;
					rsp_n.level_driven = 1'b1;
				end
				lbpp_pkg::REQ_TICK: begin
					if (play_q) begin
						if (hold_q != '0) begin
							hold_n = hold_q - HW'(1);
						end else begin
							advance = 1'b1;
							if (rdata_s1 == lbpp_pkg::SYM_STOP) begin
								play_n  = 1'b0;
								advance = 1'b0;
							end else if (rdata_s1 == lbpp_pkg::SYM_SEC_ON ||
								rdata_s1 == lbpp_pkg::SYM_SEC_OFF) begin
								if (lsec_q == req_s1.current_second) begin
									advance = 1'b0;
								end else begin
									lsec_n             = req_s1.current_second;
									rsp_n.led_level    = (rdata_s1 == lbpp_pkg::SYM_SEC_ON);
									rsp_n.level_driven = 1'b1;
								end
							end else if (rdata_s1 inside
								{[lbpp_pkg::SYM_OFF_FIRST:lbpp_pkg::SYM_OFF_LAST]}) begin
								rsp_n.level_driven = 1'b1;
								hold_n = (rdata_s1[HW-1:0] - HW'(1)) & lbpp_pkg::HOLD_MASK;
							end else if (rdata_s1 inside
								{[lbpp_pkg::SYM_ON_FIRST:lbpp_pkg::SYM_ON_LAST]}) begin
								rsp_n.led_level    = 1'b1;
								rsp_n.level_driven = 1'b1;
								hold_n = (rdata_s1[HW-1:0] - HW'(1)) & lbpp_pkg::HOLD_MASK;
							end
							// wrap at pattern end
							if (advance) begin
								pos_n = (pos_inc >= len_q) ? '0 : pos_inc[AW-1:0];
							end
						end
					end
				end
				default: begin
				end
			endcase
			rsp_n.blinking = play_n;
		end
	end

	// State update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			len_q  <= '0;
			hold_q <= '0;
			lsec_q <= '0;
			play_q <= 1'b0;
		end else if (adv_s1) begin
			pos_q  <= pos_n;
			len_q  <= len_n;
			hold_q <= hold_n;
			lsec_q <= lsec_n;
			play_q <= play_n;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
		end else if (adv_s1) begin
			rsp_valid <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			rsp_word <= rsp_n;
		end
	end

	// Checks
	a_hold_implies_play: assert property (@(posedge clk) disable iff (!arst_n)
		(hold_q != '0) |-> play_q)
		else $error("hold count nonzero while not playing");

	a_pos_in_pattern: assert property (@(posedge clk) disable iff (!arst_n)
		play_q |-> (LW'(pos_q) < len_q))
		else $error("play position beyond pattern length");

	// read data may be unknown when an unwritten entry was fetched, so compare exactly
	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv_s1) |=>
		(valid_s1 && $stable(req_s1) && (rdata_s1 === $past(rdata_s1))))
		else $error("stage 1 word changed while stalled");

	a_level_driven: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_word.led_level) |-> rsp_word.level_driven)
		else $error("led level set without being driven");

endmodule

### sim/tb_led_blink_pattern_player.sv
// ----------------------------------------------------------------------------
// tb_led_blink_pattern_player: self-checking bench for the LED pattern player
// Drives request words through the valid/stall port with random gaps. A local
// blink predictor computes the expected response word for every accepted
// request. A response monitor with random stall compares each response word,
// field by field, against the oldest expected word.
// ----------------------------------------------------------------------------
module tb_led_blink_pattern_player;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] REQ_UNUSED  = 2'd3;
	localparam int         CYCLE_LIMIT = 400_000;
	localparam int         MAX_SHOWN   = 10;

	logic           clk;
	logic           arst_n;
	logic           req_valid;
	logic           req_stall;
	lbpp_pkg::req_t req_word;
	logic           rsp_valid;
	logic           rsp_stall;
	lbpp_pkg::rsp_t rsp_word;

	led_blink_pattern_player u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_word  (req_word),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_word  (rsp_word)
	);

	// Predictor state
	logic [7:0]                  pat_mem     [lbpp_pkg::PATTERN_DEPTH];
	bit                          pat_written [lbpp_pkg::PATTERN_DEPTH];
	logic [lbpp_pkg::LEN_W-1:0]  pat_len     = '0;
	logic [lbpp_pkg::ADDR_W-1:0] play_pos    = '0;
	logic [lbpp_pkg::HOLD_W-1:0] hold_cnt    = '0;
	logic [31:0]                 sec_seen    = '0;
	bit                          playing_now = 1'b0;

	// Bench bookkeeping
	lbpp_pkg::rsp_t exp_rsp_q[$];
	int             err_cnt    = 0;
	int             items_done = 0;
	int unsigned    cycle_cnt  = 0;
	bit             no_idle    = 1'b0;
	logic [31:0]    sec_now    = '0;

	// Clock, cycle counter and watchdog
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

	initial begin
		wait (cycle_cnt >= CYCLE_LIMIT);
		$display("RESULT: ERROR");
		$finish;
	end

	// Expected response for one request; advances the predictor state
	function automatic lbpp_pkg::rsp_t blink_step(lbpp_pkg::req_t w);
		lbpp_pkg::rsp_t r;
		logic [7:0]     s;
		bit             adv;
		r = '0;
		case (w.req_type)
			lbpp_pkg::REQ_LOAD: begin
				if (int'(w.symbol_index) >= lbpp_pkg::PATTERN_DEPTH) begin
					r.load_error = 1'b1;
				end else begin
					pat_mem[w.symbol_index]     = w.pattern_symbol;
					pat_written[w.symbol_index] = 1'b1;
					if (w.last_symbol) begin
						pat_len     = lbpp_pkg::LEN_W'(w.symbol_index) + 1'b1;
						play_pos    = '0;
						hold_cnt    = '0;
						playing_now = 1'b1;
					end
				end
			end
			lbpp_pkg::REQ_STEADY: begin
				playing_now    = 1'b0;
				hold_cnt       = '0;
				r.led_level    = w.steady_level;
				r.level_driven = 1'b1;
			end
			lbpp_pkg::REQ_TICK: begin
				if (playing_now && hold_cnt != '0) begin
					hold_cnt = hold_cnt - 1'b1;
				end else if (playing_now) begin
					s   = pat_mem[play_pos];
					adv = 1'b1;
					if (s == lbpp_pkg::SYM_STOP) begin
						playing_now = 1'b0;
						adv         = 1'b0;
					end else if (s == lbpp_pkg::SYM_SEC_ON || s == lbpp_pkg::SYM_SEC_OFF) begin
						// once per new second; same second holds position
						if (sec_seen == w.current_second) begin
							adv = 1'b0;
						end else begin
							sec_seen       = w.current_second;
							r.led_level    = (s == lbpp_pkg::SYM_SEC_ON);
							r.level_driven = 1'b1;
						end
					end else if (s >= lbpp_pkg::SYM_OFF_FIRST &&
						s <= lbpp_pkg::SYM_OFF_LAST) begin
						r.level_driven = 1'b1;
						hold_cnt       = lbpp_pkg::HOLD_W'((s & lbpp_pkg::HOLD_MASK) - 1'b1);
					end else if (s >= lbpp_pkg::SYM_ON_FIRST &&
						s <= lbpp_pkg::SYM_ON_LAST) begin
						r.led_level    = 1'b1;
						r.level_driven = 1'b1;
						hold_cnt       = lbpp_pkg::HOLD_W'((s & lbpp_pkg::HOLD_MASK) - 1'b1);
					end
					if (adv) begin
						if (lbpp_pkg::LEN_W'(play_pos) + 1'b1 >= pat_len)
							play_pos = '0;
						else
							play_pos = play_pos + 1'b1;
					end
				end
			end
			default: ;
		endcase
		r.blinking = playing_now;
		return r;
	endfunction

	// Playback must never reach a store entry that was never written
	function automatic bit prefix_written(logic [lbpp_pkg::IDX_W-1:0] idx);
		for (int i = 0; i < int'(idx); i++)
			if (!pat_written[i])
				return 1'b0;
		return 1'b1;
	endfunction

	// Mostly short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic lbpp_pkg::req_t rand_word();
		logic [63:0] raw;
		raw = {$urandom, $urandom};
		return raw[$bits(lbpp_pkg::req_t)-1:0];
	endfunction

	function automatic logic [7:0] pick_symbol();
		int r;
		r = $urandom_range(0, 99);
		if (r < 30)
			return lbpp_pkg::SYM_OFF_FIRST + 8'($urandom_range(0, 9));
		if (r < 60)
			return lbpp_pkg::SYM_ON_FIRST + 8'($urandom_range(0, 9));
		if (r < 68)
			return lbpp_pkg::SYM_SEC_ON;
		if (r < 76)
			return lbpp_pkg::SYM_SEC_OFF;
		if (r < 80)
			return lbpp_pkg::SYM_STOP;
		return 8'($urandom);
	endfunction

	// Wall clock mostly steady or stepping by one, sometimes jumping anywhere
	function automatic logic [31:0] next_second();
		int r;
		r = $urandom_range(0, 99);
		if (r >= 90)
			sec_now = $urandom;
		else if (r >= 50)
			sec_now = sec_now + 1;
		return sec_now;
	endfunction

	// Steady, unused type, stray store write or restart of the current pattern
	function automatic lbpp_pkg::req_t noise_word();
		lbpp_pkg::req_t w;
		int             r;
		w = rand_word();
		r = $urandom_range(0, 3);
		case (r)
			0: w.req_type = lbpp_pkg::REQ_STEADY;
			1: w.req_type = REQ_UNUSED;
			2: begin
				w.req_type    = lbpp_pkg::REQ_LOAD;
				w.last_symbol = 1'b0;
			end
			default: begin
				w.req_type       = lbpp_pkg::REQ_LOAD;
				w.last_symbol    = 1'b1;
				w.pattern_symbol = pick_symbol();
				w.symbol_index   = (pat_len == '0) ? '0 :
					lbpp_pkg::IDX_W'($urandom_range(0, int'(pat_len) - 1));
			end
		endcase
		return w;
	endfunction

	// Send one request word; predict its response once accepted
	task automatic send_req(lbpp_pkg::req_t w);
		int gap;
		if (w.req_type == lbpp_pkg::REQ_LOAD && w.last_symbol &&
			!prefix_written(w.symbol_index))
			w.last_symbol = 1'b0;
		gap = pick_gap();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_word  <= w;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		items_done++;
		exp_rsp_q.push_back(blink_step(w));
	endtask

	task automatic send_tick(logic [31:0] sec);
		lbpp_pkg::req_t w;
		w                = rand_word();
		w.req_type       = lbpp_pkg::REQ_TICK;
		w.current_second = sec;
		send_req(w);
	endtask

	task automatic send_load(int idx, logic [7:0] sym, bit last);
		lbpp_pkg::req_t w;
		w                = rand_word();
		w.req_type       = lbpp_pkg::REQ_LOAD;
		w.symbol_index   = lbpp_pkg::IDX_W'(idx);
		w.pattern_symbol = sym;
		w.last_symbol    = last;
		send_req(w);
	endtask

	task automatic wait_results_done();
		req_valid <= 1'b0;
		@(posedge clk);
		while (exp_rsp_q.size() != 0) @(posedge clk);
	endtask

	// Load a fresh pattern, then tick through it with some noise mixed in
	task automatic play_burst();
		int  n_sym;
		int  n_tick;
		bit  broken;
		n_sym  = ($urandom_range(0, 19) == 0) ? $urandom_range(13, 48) : $urandom_range(1, 12);
		broken = ($urandom_range(0, 9) == 0);
		for (int i = 0; i < n_sym; i++)
			send_load(i, pick_symbol(), (i == n_sym - 1) && !broken);
		n_tick = $urandom_range(4, 40);
		for (int i = 0; i < n_tick; i++) begin
			if ($urandom_range(0, 9) == 0)
				send_req(noise_word());
			send_tick(next_second());
		end
	endtask

	// Response monitor with random stall
	task automatic check_rsp(lbpp_pkg::rsp_t got);
		lbpp_pkg::rsp_t exp;
		if (exp_rsp_q.size() == 0) begin
			err_cnt++;
			if (err_cnt <= MAX_SHOWN)
				$display("unexpected response word %b at cycle %0d", got, cycle_cnt);
			return;
		end
		exp = exp_rsp_q.pop_front();
		if (got.led_level !== exp.led_level || got.level_driven !== exp.level_driven ||
		    got.blinking !== exp.blinking || got.load_error !== exp.load_error) begin
			err_cnt++;
			if (err_cnt <= MAX_SHOWN)
				$display("mismatch at cycle %0d: lvl/drv/blink/lerr exp %b%b%b%b got %b%b%b%b",
					cycle_cnt, exp.led_level, exp.level_driven, exp.blinking, exp.load_error,
					got.led_level, got.level_driven, got.blinking, got.load_error);
		end
	endtask

	initial begin : rsp_side
		int stall_left;
		stall_left = 0;
		rsp_stall  = 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_valid && !rsp_stall)
				check_rsp(rsp_word);
			if (stall_left > 0)
				stall_left--;
			else
				stall_left = pick_gap();
			rsp_stall <= (stall_left > 0) && !no_idle;
		end
	end

	// Directed: requests that leave an idle player alone or force a level
	task automatic test_idle_requests();
		lbpp_pkg::req_t w;
		send_tick($urandom);
		w          = rand_word();
		w.req_type = REQ_UNUSED;
		send_req(w);
		w              = rand_word();
		w.req_type     = lbpp_pkg::REQ_STEADY;
		w.steady_level = 1'b1;
		send_req(w);
		w.steady_level = 1'b0;
		send_req(w);
	endtask

	// Directed: one of each symbol class, same-second hold, stop symbol
	task automatic test_pattern_symbols();
		send_load(0, lbpp_pkg::SYM_ON_FIRST, 1'b0);
		send_load(1, lbpp_pkg::SYM_OFF_FIRST, 1'b0);
		send_load(2, lbpp_pkg::SYM_SEC_ON, 1'b0);
		send_load(3, lbpp_pkg::SYM_SEC_OFF, 1'b0);
		send_load(4, 8'h00, 1'b0);
		send_load(5, 8'hFF, 1'b0);
		send_load(6, lbpp_pkg::SYM_STOP, 1'b1);
		send_tick(32'd0);
		send_tick(32'd0);
		send_tick(32'd0);          // same second as after reset: held
		send_tick(32'hFFFF_FFFF);
		send_tick(32'hFFFF_FFFF);  // same second on the off symbol
		send_tick(32'd1);
		send_tick(32'd1);
		send_tick(32'd1);
		send_tick(32'd1);          // stop
		send_tick(32'd2);          // stopped: nothing happens
	endtask

	task automatic test_random_play(int n_items);
		int stop_at;
		stop_at = items_done + n_items;
		while (items_done < stop_at) begin
			if ($urandom_range(0, 3) == 0)
				repeat ($urandom_range(1, 6)) send_req(noise_word());
			else
				play_burst();
		end
	endtask

	// No gaps on either side
	task automatic test_back_to_back(int n_items);
		no_idle = 1'b1;
		test_random_play(n_items);
		no_idle = 1'b0;
	endtask

	// Sender holds off until every response has come back
	task automatic test_drain_pause();
		repeat (3) begin
			play_burst();
			wait_results_done();
		end
	endtask

	// Sequence of tests
	initial begin
		for (int i = 0; i < lbpp_pkg::PATTERN_DEPTH; i++) begin
			pat_mem[i]     = '0;
			pat_written[i] = 1'b0;
		end
		arst_n    = 1'b0;
		req_valid = 1'b0;
		req_word  = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_idle_requests();
		test_pattern_symbols();
		test_random_play(400);
		test_back_to_back(150);
		test_drain_pause();
		test_random_play(250);

		wait_results_done();
		repeat (8) @(posedge clk);
		if (err_cnt == 0 && exp_rsp_q.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

### sim.f
hw/rtl/lbpp_pkg.sv
hw/rtl/led_blink_pattern_player.sv
sim/tb_led_blink_pattern_player.sv
